// ----- rtl/abst_pkg.sv -----
// ----------------------------------------------------------------------------
// abst_pkg
// Shared types and codes for the A/B boot slot state tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package abst_pkg;

    localparam int SEQ_W   = 32;
    localparam int SLOT_W  = 2;
    localparam int COUNT_W = 8;
    localparam int FLAG_W  = 32;
    localparam int RSLOT_W = 8;
    localparam int OP_W    = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_DEFAULT = 3'd0;
    localparam logic [OP_W-1:0] OP_OFFER   = 3'd1;
    localparam logic [OP_W-1:0] OP_BEGIN   = 3'd2;
    localparam logic [OP_W-1:0] OP_TRIAL   = 3'd3;
    localparam logic [OP_W-1:0] OP_CONFIRM = 3'd4;
    localparam logic [OP_W-1:0] OP_ROLL    = 3'd5;

    // slot codes
    localparam logic [SLOT_W-1:0] SLOT_NONE = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_A    = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_B    = 2'd2;

    localparam logic [COUNT_W-1:0] RESET_TRIAL_LIMIT = 8'd3;

    // register index of default_trial_limit
    localparam logic REG_DEFAULT_LIMIT = 1'b0;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [RSLOT_W-1:0] target_slot;
        logic [SEQ_W-1:0]   rec_sequence;
        logic [RSLOT_W-1:0] rec_confirmed;
        logic [RSLOT_W-1:0] rec_pending;
        logic [COUNT_W-1:0] rec_trials;
        logic [COUNT_W-1:0] rec_limit;
        logic [FLAG_W-1:0]  rec_flag_word;
        logic               rec_header_ok;
        logic               rec_crc_ok;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  chosen_slot;
        logic [SEQ_W-1:0]   seq_now;
        logic [SLOT_W-1:0]  confirmed_now;
        logic [SLOT_W-1:0]  pending_now;
        logic [COUNT_W-1:0] trials_now;
        logic [COUNT_W-1:0] limit_now;
        logic [FLAG_W-1:0]  flags_now;
        logic               found_now;
        logic               applied;
    } result_t;

    // true for slot A or slot B on an 8-bit record or target field
    function automatic logic slot_ok(input logic [RSLOT_W-1:0] s);
        return (s == {{(RSLOT_W-SLOT_W){1'b0}}, SLOT_A}) ||
               (s == {{(RSLOT_W-SLOT_W){1'b0}}, SLOT_B});
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ab_boot_slot_state_tracker_core.sv -----
// ----------------------------------------------------------------------------
// ab_boot_slot_state_tracker_core
// Top level: stream in/out pipeline around the A/B boot state tracker.
// ----------------------------------------------------------------------------
// Each accepted beat carries one opcode and produces exactly one result beat
// with the boot state after that opcode and the slot to boot. The block takes
// one beat per cycle while the output is not stalled; a beat is held in the
// input register and its result is then registered in the output register.
// The state update for a beat happens as it moves from the input register to
// the output register, so the next beat sees it.
// A stalled output holds one result while one more beat waits in the input
// register. The default trial limit register is written over APB at byte 0.
`default_nettype none

module ab_boot_slot_state_tracker_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // opcode [2:0]
    input  wire logic [2:0]   s_tuser,
    // target_slot[7:0] rec_sequence[39:8] rec_confirmed[47:40]
    // rec_pending[55:48] rec_trials[63:56] rec_limit[71:64]
    // rec_flag_word[103:72] rec_header_ok[104] rec_crc_ok[105]
    input  wire logic [111:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // chosen_slot[1:0] seq_now[33:2] confirmed_now[35:34] pending_now[37:36]
    // trials_now[45:38] limit_now[53:46] flags_now[85:54] found_now[86]
    // applied[87]
    output logic      [87:0]  m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    logic              in_valid_reg;
    abst_pkg::item_t   item_reg;
    logic              out_valid_reg;
    logic [87:0]       out_data_reg;
    logic              advance;
    logic              s_fire;
    logic [7:0]        cfg_limit;
    abst_pkg::result_t result;

    abst_apb_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg_limit (cfg_limit)
    );

    abst_state_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (item_reg),
        .cfg_limit (cfg_limit),
        .result    (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.opcode        <= s_tuser;
            item_reg.target_slot   <= s_tdata[7:0];
            item_reg.rec_sequence  <= s_tdata[39:8];
            item_reg.rec_confirmed <= s_tdata[47:40];
            item_reg.rec_pending   <= s_tdata[55:48];
            item_reg.rec_trials    <= s_tdata[63:56];
            item_reg.rec_limit     <= s_tdata[71:64];
            item_reg.rec_flag_word <= s_tdata[103:72];
            item_reg.rec_header_ok <= s_tdata[104];
            item_reg.rec_crc_ok    <= s_tdata[105];
        end
        if (advance) begin
            out_data_reg <= {result.applied, result.found_now, result.flags_now,
                             result.limit_now, result.trials_now,
                             result.pending_now, result.confirmed_now,
                             result.seq_now, result.chosen_slot};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/abst_apb_regs.sv -----
// ----------------------------------------------------------------------------
// abst_apb_regs
// APB register file holding the default trial limit.
// ----------------------------------------------------------------------------
`default_nettype none

module abst_apb_regs (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  cfg_limit
);

    logic [7:0] limit_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready &&
                    (paddr[2] == abst_pkg::REG_DEFAULT_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= abst_pkg::RESET_TRIAL_LIMIT;
        end else if (wr_en) begin
            limit_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == abst_pkg::REG_DEFAULT_LIMIT) begin
            prdata = {24'd0, limit_reg};
        end
    end

    assign cfg_limit = limit_reg;

endmodule

`default_nettype wire

// ----- rtl/abst_state_core.sv -----
// ----------------------------------------------------------------------------
// abst_state_core
// Boot state registers and the single-pass update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module abst_state_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire abst_pkg::item_t item,
    input  wire logic [7:0]      cfg_limit,
    output abst_pkg::result_t    result
);

    logic [31:0] sequence_reg, sequence_next;
    logic [1:0]  confirmed_reg, confirmed_next;
    logic [1:0]  pending_reg, pending_next;
    logic [7:0]  trial_reg, trial_next;
    logic [7:0]  limit_reg, limit_next;
    logic [31:0] flag_word_reg, flag_word_next;
    logic        found_reg, found_next;
    logic        applied;

    logic        rec_good;
    logic        rec_newer;
    logic [31:0] seq_diff;
    logic [31:0] seq_inc;
    logic        tgt_ok;
    logic        has_pending;

    assign seq_inc     = sequence_reg + 32'd1;
    assign seq_diff    = item.rec_sequence - sequence_reg;
    // newer means the signed difference is strictly positive
    assign rec_newer   = (seq_diff != 32'd0) && !seq_diff[31];
    assign has_pending = (pending_reg != abst_pkg::SLOT_NONE);
    assign rec_good    = item.rec_header_ok && item.rec_crc_ok &&
                         abst_pkg::slot_ok(item.rec_confirmed) &&
                         ((item.rec_pending == 8'd0) ||
                          abst_pkg::slot_ok(item.rec_pending)) &&
                         (item.rec_pending != item.rec_confirmed) &&
                         (item.rec_limit != 8'd0) &&
                         (item.rec_trials <= item.rec_limit);
    assign tgt_ok      = abst_pkg::slot_ok(item.target_slot) &&
                         (item.target_slot != {6'd0, confirmed_reg});

    always_comb begin
        sequence_next  = sequence_reg;
        confirmed_next = confirmed_reg;
        pending_next   = pending_reg;
        trial_next     = trial_reg;
        limit_next     = limit_reg;
        flag_word_next = flag_word_reg;
        found_next     = found_reg;
        applied        = 1'b0;
        unique case (item.opcode)
            abst_pkg::OP_DEFAULT: begin
                sequence_next  = 32'd0;
                confirmed_next = abst_pkg::SLOT_A;
                pending_next   = abst_pkg::SLOT_NONE;
                trial_next     = 8'd0;
                limit_next     = cfg_limit;
                flag_word_next = 32'd0;
                found_next     = 1'b0;
                applied        = 1'b1;
            end
            abst_pkg::OP_OFFER: begin
                if (rec_good && (!found_reg || rec_newer)) begin
                    sequence_next  = item.rec_sequence;
                    confirmed_next = item.rec_confirmed[1:0];
                    pending_next   = item.rec_pending[1:0];
                    trial_next     = item.rec_trials;
                    limit_next     = item.rec_limit;
                    flag_word_next = item.rec_flag_word;
                    found_next     = 1'b1;
                    applied        = 1'b1;
                end
            end
            abst_pkg::OP_BEGIN: begin
                if (tgt_ok) begin
                    sequence_next = seq_inc;
                    pending_next  = item.target_slot[1:0];
                    trial_next    = 8'd0;
                    limit_next    = cfg_limit;
                    applied       = 1'b1;
                end
            end
            abst_pkg::OP_TRIAL: begin
                if (has_pending && (trial_reg < limit_reg)) begin
                    sequence_next = seq_inc;
                    trial_next    = trial_reg + 8'd1;
                    applied       = 1'b1;
                end
            end
            abst_pkg::OP_CONFIRM: begin
                if (has_pending) begin
                    sequence_next  = seq_inc;
                    confirmed_next = pending_reg;
                    pending_next   = abst_pkg::SLOT_NONE;
                    trial_next     = 8'd0;
                    applied        = 1'b1;
                end
            end
            abst_pkg::OP_ROLL: begin
                if (has_pending) begin
                    sequence_next = seq_inc;
                    pending_next  = abst_pkg::SLOT_NONE;
                    trial_next    = 8'd0;
                    applied       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sequence_reg  <= 32'd0;
            confirmed_reg <= abst_pkg::SLOT_A;
            pending_reg   <= abst_pkg::SLOT_NONE;
            trial_reg     <= 8'd0;
            limit_reg     <= abst_pkg::RESET_TRIAL_LIMIT;
            flag_word_reg <= 32'd0;
            found_reg     <= 1'b0;
        end else if (step) begin
            sequence_reg  <= sequence_next;
            confirmed_reg <= confirmed_next;
            pending_reg   <= pending_next;
            trial_reg     <= trial_next;
            limit_reg     <= limit_next;
            flag_word_reg <= flag_word_next;
            found_reg     <= found_next;
        end
    end

    always_comb begin
        result.chosen_slot   = ((pending_next != abst_pkg::SLOT_NONE) &&
                                (trial_next < limit_next)) ? pending_next
                                                           : confirmed_next;
        result.seq_now       = sequence_next;
        result.confirmed_now = confirmed_next;
        result.pending_now   = pending_next;
        result.trials_now    = trial_next;
        result.limit_now     = limit_next;
        result.flags_now     = flag_word_next;
        result.found_now     = found_next;
        result.applied       = applied;
    end

endmodule

`default_nettype wire

// ----- rtl/abst_checker.sv -----
// ----------------------------------------------------------------------------
// abst_checker
// Port-level assertions for the boot slot state tracker, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module abst_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic [87:0] m_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    logic [1:0]  chosen;
    logic [1:0]  conf;
    logic [1:0]  pend;
    logic [31:0] flags;
    logic        found;

    assign chosen = m_tdata[1:0];
    assign conf   = m_tdata[35:34];
    assign pend   = m_tdata[37:36];
    assign flags  = m_tdata[85:54];
    assign found  = m_tdata[86];

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // confirmed is always A or B, pending is none or the other slot
    a_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (conf == abst_pkg::SLOT_A || conf == abst_pkg::SLOT_B) &&
                     (pend != 2'd3) && (pend != conf))
        else $error("inconsistent slot state");

    // chosen slot is the confirmed one or a live pending one
    a_chosen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (chosen == conf) ||
                     (chosen == pend && pend != abst_pkg::SLOT_NONE))
        else $error("chosen slot not confirmed or pending");

    // flags only come from an adopted record
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !found |-> flags == 32'd0)
        else $error("flags set with no record found");

endmodule

bind ab_boot_slot_state_tracker_core abst_checker u_abst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
